// File: hw/rtl/hcbp_pkg.sv
// ----------------------------------------------------------------------------
// hcbp_pkg
// Shared types and constants of the huffman code bit packer: item field
// widths, mode codes and the operation record passed from front to back.
// ----------------------------------------------------------------------------
package hcbp_pkg;

	// field widths of one input item
	localparam int MODE_BITS    = 2;
	localparam int SYM_BITS     = 8;
	localparam int CODE_BITS    = 32;
	localparam int LEN_BITS     = 6;
	localparam int IN_DATA_BITS = 48;

	// result word width and longest code
	localparam int OUT_BITS     = 32;
	localparam int CODE_MAX_LEN = 32;

	// queue between front and back
	localparam int QUEUE_DEPTH  = 4;
	localparam int QUEUE_AW     = 2;
	localparam int QCNT_BITS    = 3;

	// item modes
	localparam logic [MODE_BITS-1:0] MODE_LOAD   = 2'd0;
	localparam logic [MODE_BITS-1:0] MODE_ENCODE = 2'd1;
	localparam logic [MODE_BITS-1:0] MODE_FLUSH  = 2'd2;

	// classified operation for the back end
	typedef struct packed {
		logic                 is_flush;
		logic [LEN_BITS-1:0]  len;
		logic [CODE_BITS-1:0] code;
	} op_t;

	// queue status seen by the front and back
	typedef struct packed {
		logic not_empty;
		logic room2;
	} q_stat_t;

endpackage

// File: hw/rtl/hcbp_ram.sv
// ----------------------------------------------------------------------------
// hcbp_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module hcbp_ram #(
	parameter int WIDTH = 38,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

// File: hw/rtl/hcbp_front.sv
// ----------------------------------------------------------------------------
// hcbp_front
// Accepts input transactions, writes and reads the code table and hands
// classified append and flush operations to the queue.
// ----------------------------------------------------------------------------
module hcbp_front #(
	parameter int TABLE_DEPTH = 256,
	parameter int WORD_BITS   = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// symbol[7:0], code_bits[39:8], code_length[45:40], zero pad
	input  logic [hcbp_pkg::IN_DATA_BITS-1:0]    s_tdata,
	// mode[1:0]
	input  logic [hcbp_pkg::MODE_BITS-1:0]       s_tuser,
	input  hcbp_pkg::q_stat_t                    q_stat,
	output logic                                 push_valid,
	output hcbp_pkg::op_t                        push_op
);

	localparam int AW      = $clog2(TABLE_DEPTH);
	localparam int ENT_W   = hcbp_pkg::CODE_BITS + hcbp_pkg::LEN_BITS;
	localparam int LEN_LIM = (WORD_BITS < hcbp_pkg::CODE_MAX_LEN) ?
		WORD_BITS : hcbp_pkg::CODE_MAX_LEN;

	logic [hcbp_pkg::SYM_BITS-1:0]  sym;
	logic [hcbp_pkg::CODE_BITS-1:0] code_in;
	logic [hcbp_pkg::LEN_BITS-1:0]  len_in;
	logic                           accept;
	logic                           sym_ok;
	logic                           ram_we;
	logic                           ram_re;
	logic                           is_flush;
	logic [ENT_W-1:0]               ram_rdata;

	logic                           valid_s1;
	logic                           flush_s1;

	logic [hcbp_pkg::LEN_BITS-1:0]  len_raw;
	logic [hcbp_pkg::LEN_BITS-1:0]  len_sat;
	logic [hcbp_pkg::CODE_BITS:0]   mask_wide;

	assign sym     = s_tdata[7:0];
	assign code_in = s_tdata[39:8];
	assign len_in  = s_tdata[45:40];

	// at most one item in flight plus one new item must fit in the queue
	assign s_tready = q_stat.room2;
	assign accept   = s_tvalid & s_tready;
	assign sym_ok   = {1'b0, sym} < (hcbp_pkg::SYM_BITS + 1)'(TABLE_DEPTH);

	// mode decode
	always_comb begin
		ram_we   = 1'b0;
		ram_re   = 1'b0;
		is_flush = 1'b0;
		unique case (s_tuser)
			hcbp_pkg::MODE_LOAD: begin
				ram_we = accept & sym_ok;
			end
			hcbp_pkg::MODE_ENCODE: begin
				ram_re = accept & sym_ok;
			end
			hcbp_pkg::MODE_FLUSH: begin
				is_flush = accept;
			end
			default: begin
			end
		endcase
	end

	// code table: length in the upper bits, code value below
	hcbp_ram #(
		.WIDTH(ENT_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.re   (ram_re),
		.addr (sym[AW-1:0]),
		.wdata({len_in, code_in}),
		.rdata(ram_rdata)
	);

	// stage 1 holds the kind while the table read completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= ram_re | is_flush;
		end
	end

	always_ff @(posedge clk) begin
		flush_s1 <= is_flush;
	end

	// saturate the length and drop stray code bits
	assign len_raw   = ram_rdata[ENT_W-1:hcbp_pkg::CODE_BITS];
	assign len_sat   = (len_raw > hcbp_pkg::LEN_BITS'(LEN_LIM)) ?
		hcbp_pkg::LEN_BITS'(LEN_LIM) : len_raw;
	assign mask_wide = ((hcbp_pkg::CODE_BITS + 1)'(1) << len_sat) -
		(hcbp_pkg::CODE_BITS + 1)'(1);

	// a zero-length code appends nothing and is not queued
	always_comb begin
		push_op.is_flush = flush_s1;
		push_op.len      = flush_s1 ? '0 : len_sat;
		push_op.code     = flush_s1 ? '0 :
			(ram_rdata[hcbp_pkg::CODE_BITS-1:0] & mask_wide[hcbp_pkg::CODE_BITS-1:0]);
		push_valid       = valid_s1 & (flush_s1 | (len_sat != '0));
	end

endmodule

// File: hw/rtl/hcbp_queue.sv
// ----------------------------------------------------------------------------
// hcbp_queue
// Short first-in first-out queue of operations between front and back.
// ----------------------------------------------------------------------------
module hcbp_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	input  hcbp_pkg::op_t     push_op,
	input  logic              pop,
	output hcbp_pkg::q_stat_t q_stat,
	output hcbp_pkg::op_t     head_op
);

	hcbp_pkg::op_t                     slot_q [hcbp_pkg::QUEUE_DEPTH];
	logic [hcbp_pkg::QUEUE_AW-1:0]     wr_ptr_q;
	logic [hcbp_pkg::QUEUE_AW-1:0]     rd_ptr_q;
	logic [hcbp_pkg::QCNT_BITS-1:0]    count_q;
	logic                              do_pop;

	assign do_pop           = pop & (count_q != '0);
	assign head_op          = slot_q[rd_ptr_q];
	assign q_stat.not_empty = (count_q != '0);
	assign q_stat.room2     = (count_q <= hcbp_pkg::QCNT_BITS'(hcbp_pkg::QUEUE_DEPTH - 2));

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push_valid & ~do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (~push_valid & do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push_valid) begin
			slot_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

// File: hw/rtl/hcbp_back.sv
// ----------------------------------------------------------------------------
// hcbp_back
// Bit accumulator: appends codes, emits full words, and on a flush with bits
// pending emits the bit count and the left-aligned last word.
// ----------------------------------------------------------------------------
module hcbp_back #(
	parameter int WORD_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  hcbp_pkg::q_stat_t             q_stat,
	input  hcbp_pkg::op_t                 head_op,
	output logic                          pop,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// word[31:0]
	output logic [hcbp_pkg::OUT_BITS-1:0] m_tdata,
	// is_bit_count
	output logic                          m_tuser,
	output logic                          m_tlast
);

	localparam int CW  = $clog2(WORD_BITS);
	localparam int TW  = CW + 1;
	localparam int CBW = WORD_BITS + hcbp_pkg::CODE_BITS;
	localparam int XW  = WORD_BITS + hcbp_pkg::OUT_BITS;

	logic [WORD_BITS-1:0]          acc_q;
	logic [CW-1:0]                 cnt_q;

	logic                          out_valid_q;
	logic [hcbp_pkg::OUT_BITS-1:0] out_word_q;
	logic                          out_isc_q;
	logic                          out_last_q;
	logic                          hold_valid_q;
	logic [hcbp_pkg::OUT_BITS-1:0] hold_word_q;

	logic                          out_free;
	logic [CBW-1:0]                combined;
	logic [TW-1:0]                 total;
	logic [TW-1:0]                 rem;
	logic                          word_full;
	logic [CBW-1:0]                shifted;
	logic [WORD_BITS-1:0]          rem_mask;
	logic [TW-1:0]                 flush_sh;
	logic [WORD_BITS-1:0]          flush_word;
	logic [XW-1:0]                 emit_wide;
	logic [XW-1:0]                 flush_wide;

	assign out_free = ~out_valid_q | m_tready;
	assign pop      = q_stat.not_empty & out_free & ~hold_valid_q;

	// append datapath
	assign combined  = (CBW'(acc_q) << head_op.len) | CBW'(head_op.code);
	assign total     = TW'(cnt_q) + TW'(head_op.len);
	assign word_full = (total >= TW'(WORD_BITS));
	assign rem       = total - TW'(WORD_BITS);
	assign shifted   = combined >> rem;
	assign rem_mask  = (WORD_BITS'(1) << rem) - WORD_BITS'(1);
	assign emit_wide = XW'(shifted[WORD_BITS-1:0]);

	// flush datapath
	assign flush_sh   = TW'(WORD_BITS) - TW'(cnt_q);
	assign flush_word = acc_q << flush_sh;
	assign flush_wide = XW'(flush_word);

	// accumulator and pending count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
		end else if (pop) begin
			if (head_op.is_flush) begin
				acc_q <= '0;
				cnt_q <= '0;
			end else if (word_full) begin
				acc_q <= combined[WORD_BITS-1:0] & rem_mask;
				cnt_q <= rem[CW-1:0];
			end else begin
				acc_q <= combined[WORD_BITS-1:0];
				cnt_q <= total[CW-1:0];
			end
		end
	end

	// output register and held second result of a flush
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			hold_valid_q <= 1'b0;
		end else if (out_free) begin
			if (hold_valid_q) begin
				out_valid_q  <= 1'b1;
				hold_valid_q <= 1'b0;
			end else if (pop & head_op.is_flush & (cnt_q != '0)) begin
				out_valid_q  <= 1'b1;
				hold_valid_q <= 1'b1;
			end else if (pop & ~head_op.is_flush & word_full) begin
				out_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (hold_valid_q) begin
				out_word_q <= hold_word_q;
				out_isc_q  <= 1'b0;
				out_last_q <= 1'b1;
			end else if (pop & head_op.is_flush) begin
				out_word_q  <= hcbp_pkg::OUT_BITS'(cnt_q);
				out_isc_q   <= 1'b1;
				out_last_q  <= 1'b0;
				hold_word_q <= flush_wide[hcbp_pkg::OUT_BITS-1:0];
			end else if (pop) begin
				out_word_q <= emit_wide[hcbp_pkg::OUT_BITS-1:0];
				out_isc_q  <= 1'b0;
				out_last_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_word_q;
	assign m_tuser  = out_isc_q;
	assign m_tlast  = out_last_q;

endmodule

// File: hw/rtl/huffman_code_bit_packer_top.sv
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_top
// Path: an accepted encode or flush transaction passes the table read (stage 1),
// the operation queue and the output register before its result is valid.
// Throughput: one item per cycle while the queue has room and m_tready does not stall;
// a flush with bits pending gives two results, the bit count and then the last word.
// Reset: arst_n clears the accumulator, pending count, queue and valid flags;
// the code table is undefined until each entry is loaded.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer_top #(
	parameter int TABLE_DEPTH = 256,
	parameter int WORD_BITS   = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// symbol[7:0], code_bits[39:8], code_length[45:40], zero pad
	input  logic [hcbp_pkg::IN_DATA_BITS-1:0] s_tdata,
	// mode[1:0]
	input  logic [hcbp_pkg::MODE_BITS-1:0]    s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// word[31:0]
	output logic [hcbp_pkg::OUT_BITS-1:0]     m_tdata,
	// is_bit_count
	output logic                              m_tuser,
	output logic                              m_tlast
);

	hcbp_pkg::q_stat_t q_stat;
	hcbp_pkg::op_t     push_op;
	hcbp_pkg::op_t     head_op;
	logic              push_valid;
	logic              pop;

	// front: accept, table access, classification
	hcbp_front #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.WORD_BITS  (WORD_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.q_stat    (q_stat),
		.push_valid(push_valid),
		.push_op   (push_op)
	);

	// operation queue
	hcbp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_op   (push_op),
		.pop       (pop),
		.q_stat    (q_stat),
		.head_op   (head_op)
	);

	// back: bit packing and result output
	hcbp_back #(
		.WORD_BITS(WORD_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_stat  (q_stat),
		.head_op (head_op),
		.pop     (pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

endmodule
